[hw/rtl/fmc_pkg.sv]
// fmc_pkg: shared types and constants of the fragment mismatch cost block
// used by fmc_ctrl, fmc_dp and fragment_mismatch_cost_top; no dependencies
`default_nettype none

package fmc_pkg;

  // buffer and fragment limits
  localparam int MAX_BUFFER_BYTES   = 4096;
  localparam int MAX_FRAGMENT_BYTES = 256;

  // derived widths
  localparam int ADDR_W     = $clog2(MAX_BUFFER_BYTES);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int IDX_W      = CNT_W;
  localparam int POS_W      = $clog2(MAX_FRAGMENT_BYTES);
  localparam int LEN_W      = POS_W + 1;
  localparam int DATA_W     = 8;
  localparam int DIV_STEPS  = ADDR_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int FUNC_W     = 2;
  localparam int STATUS_W   = 2;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(16);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_FRAGMENT_BYTES);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR      = 2'd0,
    FUNC_APPEND_SRC = 2'd1,
    FUNC_APPEND_TGT = 2'd2,
    FUNC_QUERY      = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_BAD_INDEX = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_INIT,
    ST_DIV,
    ST_CHECK,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic div_init;
    logic div_step;
    logic check;
    logic walk_step;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;
    logic is_query;
    logic bad_idx;
    logic walk_last;
  } dp_sts_t;

endpackage

`default_nettype wire

[hw/rtl/fmc_ram.sv]
// fmc_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module fmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

[hw/rtl/fmc_ctrl.sv]
// fmc_ctrl: sequencer for one transaction (load, divide, check, walk, output)
// depends on fmc_pkg
`default_nettype none

module fmc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire fmc_pkg::dp_sts_t sts,
  output fmc_pkg::cmd_t        cmd
);
  import fmc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = sts.is_query ? ST_CHECK : ST_DONE;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.bad_idx ? ST_DONE : ST_WALK;
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // a pending result is never overwritten
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("output register loaded while holding an untaken result");

  // one transaction at a time
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a transaction was accepted");

  // a loaded result shows up on the port
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("result loaded but out_valid low");

endmodule

`default_nettype wire

[hw/rtl/fmc_dp.sv]
// fmc_dp: buffers, byte counts, fragment count dividers, compare walk, output regs
// depends on fmc_pkg and fmc_ram
`default_nettype none

module fmc_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire fmc_pkg::cmd_t                 cmd,
  output fmc_pkg::dp_sts_t                   sts,
  input  wire logic                          cfg_wr_en,
  input  wire logic [fmc_pkg::LEN_W-1:0]     cfg_wr_data,
  input  wire logic [fmc_pkg::FUNC_W-1:0]    in_func,
  input  wire logic [fmc_pkg::DATA_W-1:0]    in_data_byte,
  input  wire logic [fmc_pkg::IDX_W-1:0]     in_source_index,
  input  wire logic [fmc_pkg::IDX_W-1:0]     in_target_index,
  output logic      [fmc_pkg::LEN_W-1:0]     out_cost,
  output logic      [fmc_pkg::STATUS_W-1:0]  out_status,
  output logic      [fmc_pkg::CNT_W-1:0]     out_source_fragment_count,
  output logic      [fmc_pkg::CNT_W-1:0]     out_target_fragment_count
);
  import fmc_pkg::*;

  // config register and effective length
  logic [LEN_W-1:0] cfg_len_r;
  logic [LEN_W-1:0] len_eff;

  // latched transaction
  func_t            func_r;
  logic [IDX_W-1:0] sidx_r, tidx_r;
  logic [LEN_W-1:0] len_r;
  logic             drop_r;

  // byte counts
  logic [CNT_W-1:0] src_cnt_r, tgt_cnt_r;
  logic             src_full, tgt_full;
  logic             src_we, tgt_we;
  func_t            in_func_e;

  // dividers
  logic [ADDR_W-1:0]    s_dvd_r, t_dvd_r;
  logic [LEN_W-1:0]     s_rem_r, t_rem_r;
  logic [ADDR_W-1:0]    s_q_r, t_q_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [LEN_W:0]       s_step, t_step;
  logic [CNT_W-1:0]     s_frag, t_frag;

  // query check
  logic                     bad;
  logic                     bad_r, s_empty_r, t_empty_r;
  logic [IDX_W+LEN_W-1:0]   s_prod, t_prod;
  logic [ADDR_W-1:0]        s_base_r, t_base_r;

  // compare walk
  logic [POS_W-1:0]  pos_r;
  logic [CNT_W-1:0]  s_at, t_at;
  logic              s_ok, t_ok, s_ok_r, t_ok_r, pend_r;
  logic [DATA_W-1:0] s_rd, t_rd, s_byte, t_byte;
  logic [LEN_W-1:0]  cost_r;

  function automatic logic [LEN_W:0] div_step(input logic [LEN_W-1:0] rem,
                                              input logic             dbit,
                                              input logic [LEN_W-1:0] len);
    logic [LEN_W:0] trial;
    logic [LEN_W:0] diff;
    trial = {rem, dbit};
    diff  = trial - {1'b0, len};
    if (trial >= {1'b0, len}) begin
      div_step = {1'b1, diff[LEN_W-1:0]};
    end else begin
      div_step = {1'b0, trial[LEN_W-1:0]};
    end
  endfunction

  // length clamp: zero acts as one, anything above the max acts as the max
  always_comb begin
    if (cfg_len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (cfg_len_r > LEN_MAX) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = cfg_len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r <= LEN_RESET;
    end else if (cfg_wr_en) begin
      cfg_len_r <= cfg_wr_data;
    end
  end

  assign in_func_e = func_t'(in_func);
  assign src_full  = src_cnt_r[ADDR_W];
  assign tgt_full  = tgt_cnt_r[ADDR_W];
  assign src_we    = cmd.accept && (in_func_e == FUNC_APPEND_SRC) && !src_full;
  assign tgt_we    = cmd.accept && (in_func_e == FUNC_APPEND_TGT) && !tgt_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_cnt_r <= '0;
      tgt_cnt_r <= '0;
    end else if (cmd.accept) begin
      if (in_func_e == FUNC_CLEAR) begin
        src_cnt_r <= '0;
        tgt_cnt_r <= '0;
      end
      if (src_we) begin
        src_cnt_r <= src_cnt_r + CNT_W'(1);
      end
      if (tgt_we) begin
        tgt_cnt_r <= tgt_cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r <= in_func_e;
      sidx_r <= in_source_index;
      tidx_r <= in_target_index;
      len_r  <= len_eff;
      drop_r <= ((in_func_e == FUNC_APPEND_SRC) && src_full) ||
                ((in_func_e == FUNC_APPEND_TGT) && tgt_full);
    end
  end

  // fragment count = 1 + (bytes - 1) / len, restoring divide, one bit a cycle
  assign s_step = div_step(s_rem_r, s_dvd_r[ADDR_W-1], len_r);
  assign t_step = div_step(t_rem_r, t_dvd_r[ADDR_W-1], len_r);

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      s_dvd_r   <= src_cnt_r[ADDR_W-1:0] - ADDR_W'(1);
      t_dvd_r   <= tgt_cnt_r[ADDR_W-1:0] - ADDR_W'(1);
      s_rem_r   <= '0;
      t_rem_r   <= '0;
      s_q_r     <= '0;
      t_q_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      s_dvd_r   <= {s_dvd_r[ADDR_W-2:0], 1'b0};
      t_dvd_r   <= {t_dvd_r[ADDR_W-2:0], 1'b0};
      s_rem_r   <= s_step[LEN_W-1:0];
      t_rem_r   <= t_step[LEN_W-1:0];
      s_q_r     <= {s_q_r[ADDR_W-2:0], s_step[LEN_W]};
      t_q_r     <= {t_q_r[ADDR_W-2:0], t_step[LEN_W]};
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end
  end

  assign s_frag = (src_cnt_r == '0) ? '0 : {1'b0, s_q_r} + CNT_W'(1);
  assign t_frag = (tgt_cnt_r == '0) ? '0 : {1'b0, t_q_r} + CNT_W'(1);

  // index check and fragment base addresses
  assign bad    = (sidx_r > s_frag) || (tidx_r > t_frag);
  assign s_prod = {{LEN_W{1'b0}}, sidx_r} * {{IDX_W{1'b0}}, len_r};
  assign t_prod = {{LEN_W{1'b0}}, tidx_r} * {{IDX_W{1'b0}}, len_r};

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      bad_r     <= bad;
      s_empty_r <= (sidx_r == s_frag);
      t_empty_r <= (tidx_r == t_frag);
      s_base_r  <= s_prod[ADDR_W-1:0];
      t_base_r  <= t_prod[ADDR_W-1:0];
    end
  end

  // walk: issue one address a cycle, compare the registered read in the cycle after
  assign s_at = {1'b0, s_base_r} + {{(CNT_W-POS_W){1'b0}}, pos_r};
  assign t_at = {1'b0, t_base_r} + {{(CNT_W-POS_W){1'b0}}, pos_r};
  assign s_ok = !s_empty_r && (s_at < src_cnt_r);
  assign t_ok = !t_empty_r && (t_at < tgt_cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.walk_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      pos_r <= '0;
    end else if (cmd.walk_step) begin
      pos_r  <= pos_r + POS_W'(1);
      s_ok_r <= s_ok;
      t_ok_r <= t_ok;
    end
  end

  assign s_byte = s_ok_r ? s_rd : '0;
  assign t_byte = t_ok_r ? t_rd : '0;

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      cost_r <= '0;
    end else if (pend_r && (s_byte != t_byte)) begin
      cost_r <= cost_r + LEN_W'(1);
    end
  end

  fmc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_BUFFER_BYTES)
  ) u_src_ram (
    .clk     (clk),
    .wr_en   (src_we),
    .wr_addr (src_cnt_r[ADDR_W-1:0]),
    .wr_data (in_data_byte),
    .rd_addr (s_at[ADDR_W-1:0]),
    .rd_data (s_rd)
  );

  fmc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_BUFFER_BYTES)
  ) u_tgt_ram (
    .clk     (clk),
    .wr_en   (tgt_we),
    .wr_addr (tgt_cnt_r[ADDR_W-1:0]),
    .wr_data (in_data_byte),
    .rd_addr (t_at[ADDR_W-1:0]),
    .rd_data (t_rd)
  );

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_source_fragment_count <= s_frag;
      out_target_fragment_count <= t_frag;
      if (func_r == FUNC_QUERY) begin
        out_cost   <= bad_r ? '0 : cost_r;
        out_status <= bad_r ? STS_BAD_INDEX : STS_OK;
      end else begin
        out_cost   <= '0;
        out_status <= drop_r ? STS_FULL : STS_OK;
      end
    end
  end

  assign sts.div_last  = (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  assign sts.is_query  = (func_r == FUNC_QUERY);
  assign sts.bad_idx   = bad;
  assign sts.walk_last = ({1'b0, pos_r} == (len_r - LEN_W'(1)));

  // a partial count stays below the fragment length
  a_cost_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (cost_r < len_r))
    else $error("mismatch count ran past the fragment length");

  // byte counts never pass the buffer size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (src_cnt_r <= CNT_W'(MAX_BUFFER_BYTES)) && (tgt_cnt_r <= CNT_W'(MAX_BUFFER_BYTES)))
    else $error("byte count above buffer size");

  // a full source buffer takes no write
  a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (src_full && cmd.accept) |=> $stable(src_cnt_r) || (src_cnt_r == '0))
    else $error("source byte count moved on a full buffer");

endmodule

`default_nettype wire

[hw/rtl/fragment_mismatch_cost_top.sv]
// fragment_mismatch_cost_top: top level of the fragment mismatch cost block
// depends on fmc_pkg, fmc_ctrl, fmc_dp (and fmc_ram through fmc_dp)
//
// usage
// - input channel (in_valid / in_stall): one transaction per item, in_func selects
//   clear both buffers, append a source byte, append a target byte or query
// - result channel (out_valid / out_stall): exactly one result per input item
// - cfg_wr_en / cfg_wr_data write the fragment length (0 acts as 1, above 256 as 256);
//   write it only while no transaction is in flight
// - one item at a time: in_stall goes high for the whole transaction
// - clear and append run from accept through a load step, one divider setup and
//   12 divide steps for the fragment counts, then one output load
// - a query adds an index check, then a walk over the fragment of length L (16 after
//   reset), one byte per cycle through each buffer ram, and a drain step; a bad index skips the walk
// - a finished result sits in the output register while the next item is accepted;
//   if the receiver stalls and a second result is ready, the block holds in its done
//   state and keeps in_stall high until the first one is taken
// - reset (rst_n low, synchronous) empties both buffers, sets the fragment length to 16
//   and drops any result in flight; no clearing pass, the rams are read only below
//   the byte counts
`default_nettype none

module fragment_mismatch_cost_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic [fmc_pkg::LEN_W-1:0]     cfg_wr_data,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [fmc_pkg::FUNC_W-1:0]    in_func,
  input  wire logic [fmc_pkg::DATA_W-1:0]    in_data_byte,
  input  wire logic [fmc_pkg::IDX_W-1:0]     in_source_index,
  input  wire logic [fmc_pkg::IDX_W-1:0]     in_target_index,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [fmc_pkg::LEN_W-1:0]     out_cost,
  output logic      [fmc_pkg::STATUS_W-1:0]  out_status,
  output logic      [fmc_pkg::CNT_W-1:0]     out_source_fragment_count,
  output logic      [fmc_pkg::CNT_W-1:0]     out_target_fragment_count
);
  import fmc_pkg::*;

  // command and status between sequencer and datapath
  cmd_t    cmd;
  dp_sts_t sts;

  // sequencer: accept, divide, check, walk, output handshake
  fmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: buffer rams, counts, fragment count dividers, compare walk
  fmc_dp u_dp (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cmd                       (cmd),
    .sts                       (sts),
    .cfg_wr_en                 (cfg_wr_en),
    .cfg_wr_data               (cfg_wr_data),
    .in_func                   (in_func),
    .in_data_byte              (in_data_byte),
    .in_source_index           (in_source_index),
    .in_target_index           (in_target_index),
    .out_cost                  (out_cost),
    .out_status                (out_status),
    .out_source_fragment_count (out_source_fragment_count),
    .out_target_fragment_count (out_target_fragment_count)
  );

endmodule

`default_nettype wire
